[hw/rtl/cubic_bezier_point_and_tangent_core_assert.svh]
// Assertion macros for the cubic Bezier core.
// Used by the top level only; the macros expand to nothing when SYNTHESIS is defined.
`ifndef CUBIC_BEZIER_POINT_AND_TANGENT_CORE_ASSERT_SVH
`define CUBIC_BEZIER_POINT_AND_TANGENT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define CBZ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define CBZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CBZ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CBZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/cbz_pkg.sv]
// Shared constants and types for the cubic Bezier point and tangent core.
// No dependencies; used by cbz_lerp and the top level.
package cbz_pkg;

	localparam int T_FRAC_BITS = 16;
	localparam int T_W         = T_FRAC_BITS + 1;
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = DIFF_W + T_W + 1;
	localparam int TRI_W   = DIFF_W + 2;

	localparam int NUM_STAGES = 9;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 4 * COORD_W;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_START_X  = 3'd0,
		REG_START_Y  = 3'd1,
		REG_CTRL_A_X = 3'd2,
		REG_CTRL_A_Y = 3'd3,
		REG_CTRL_B_X = 3'd4,
		REG_CTRL_B_Y = 3'd5,
		REG_END_X    = 3'd6,
		REG_END_Y    = 3'd7
	} cfg_reg_t;

	// Load enables of the three register stages of one interpolation unit.
	typedef struct packed {
		logic d;
		logic m;
		logic a;
	} lerp_en_t;

endpackage

[hw/rtl/cubic_bezier_point_and_tangent_core.sv]
// Cubic Bezier point and tangent evaluator: nine-stage pipeline, one word per cycle while the output is taken.
// Depends on cbz_pkg, cbz_lerp and the assertion macro header.
//
// The four control points are written through the configuration port (index 0 start_x,
// 1 start_y, 2 ctrl_a_x, 3 ctrl_a_y, 4 ctrl_b_x, 5 ctrl_b_y, 6 end_x, 7 end_y; all signed
// Q16.16, reset to zero) and must only be changed while no word is in flight. Each input
// word carries t in unsigned Q1.16 (65536 is 1.0, larger values are treated as 1.0).
// The core evaluates the curve by de Casteljau subdivision: three levels of linear
// interpolation, each rounded to nearest with ties toward +infinity. The point is the
// third-level result; the tangent is three times the difference of the two second-level
// points, clamped to the signed 32-bit range, and tuser flags that clamp. Each interpolation
// level is a difference, a 33x18 multiply and a rounding add, one register stage each, and
// the tangent scaling and clamp ride alongside the last level. A new word is accepted every
// cycle while the output is taken. Each stage holds its word only while the stage after it
// is full and stalled, so bubbles collapse and the input keeps flowing while a finished
// word waits at the output until all nine stages are occupied.
module cubic_bezier_point_and_tangent_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_index,
	input  logic [cbz_pkg::COORD_W-1:0]         cfg_data,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [cbz_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [16:0] param_t, rest zero
	// output stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [cbz_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // point_x, point_y, tangent_x, tangent_y
	output logic [0:0]                          m_axis_tuser   // [0] saturated
);

	logic signed [cbz_pkg::COORD_W-1:0] regs_q [8];

	logic [1:cbz_pkg::NUM_STAGES]   valid_q;
	logic [1:cbz_pkg::NUM_STAGES+1] load;

	logic [cbz_pkg::T_W-1:0] t_in;
	logic [cbz_pkg::T_W-1:0] t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;

	cbz_pkg::lerp_en_t en_l1, en_l2, en_l3;

	logic signed [cbz_pkg::COORD_W-1:0] q0x, q1x, q2x, q0y, q1y, q2y;
	logic signed [cbz_pkg::COORD_W-1:0] r0x, r1x, r0y, r1y;
	logic signed [cbz_pkg::COORD_W-1:0] px, py;
	logic signed [cbz_pkg::DIFF_W-1:0]  dx, dy;
	logic signed [cbz_pkg::DIFF_W-1:0]  unused_d1x, unused_d1y, unused_d2x, unused_d2y;
	logic signed [cbz_pkg::DIFF_W-1:0]  unused_d3x, unused_d3y, unused_d4x, unused_d4y;
	logic signed [cbz_pkg::DIFF_W-1:0]  unused_d5x, unused_d5y;

	logic signed [cbz_pkg::TRI_W-1:0]   tri_x_s8, tri_y_s8;
	logic signed [cbz_pkg::COORD_W-1:0] tan_x_s9, tan_y_s9;
	logic                               sat_s9;
	logic signed [cbz_pkg::COORD_W-1:0] tan_x_c, tan_y_c;
	logic                               sat_x_c, sat_y_c;

	// Configuration registers; the 3-bit index covers exactly the eight registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= '0;
			end
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	// A stage loads when it is empty or its contents move on in the same cycle.
	always_comb begin
		load[cbz_pkg::NUM_STAGES+1] = m_axis_tready;
		for (int k = cbz_pkg::NUM_STAGES; k >= 1; k--) begin
			load[k] = !valid_q[k] || load[k+1];
		end
	end

	assign s_axis_tready = load[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[1]) begin
				valid_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= cbz_pkg::NUM_STAGES; k++) begin
				if (load[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// Values of t above one are treated as one.
	assign t_in = (s_axis_tdata[cbz_pkg::T_W-1:0] > cbz_pkg::T_ONE) ?
		cbz_pkg::T_ONE : s_axis_tdata[cbz_pkg::T_W-1:0];

	always_ff @(posedge clk) begin
		if (load[1]) t_s1 <= t_in;
		if (load[2]) t_s2 <= t_s1;
		if (load[3]) t_s3 <= t_s2;
		if (load[4]) t_s4 <= t_s3;
		if (load[5]) t_s5 <= t_s4;
		if (load[6]) t_s6 <= t_s5;
		if (load[7]) t_s7 <= t_s6;
	end

	assign en_l1 = '{d: load[1], m: load[2], a: load[3]};
	assign en_l2 = '{d: load[4], m: load[5], a: load[6]};
	assign en_l3 = '{d: load[7], m: load[8], a: load[9]};

	// Level one: three interpolations per axis between neighboring control points.
	cbz_lerp u_l1_q0x (.clk, .en(en_l1), .a(regs_q[cbz_pkg::REG_START_X]),
		.b(regs_q[cbz_pkg::REG_CTRL_A_X]), .t(t_s1), .res(q0x), .diff(unused_d1x));
	cbz_lerp u_l1_q1x (.clk, .en(en_l1), .a(regs_q[cbz_pkg::REG_CTRL_A_X]),
		.b(regs_q[cbz_pkg::REG_CTRL_B_X]), .t(t_s1), .res(q1x), .diff(unused_d2x));
	cbz_lerp u_l1_q2x (.clk, .en(en_l1), .a(regs_q[cbz_pkg::REG_CTRL_B_X]),
		.b(regs_q[cbz_pkg::REG_END_X]), .t(t_s1), .res(q2x), .diff(unused_d3x));
	cbz_lerp u_l1_q0y (.clk, .en(en_l1), .a(regs_q[cbz_pkg::REG_START_Y]),
		.b(regs_q[cbz_pkg::REG_CTRL_A_Y]), .t(t_s1), .res(q0y), .diff(unused_d1y));
	cbz_lerp u_l1_q1y (.clk, .en(en_l1), .a(regs_q[cbz_pkg::REG_CTRL_A_Y]),
		.b(regs_q[cbz_pkg::REG_CTRL_B_Y]), .t(t_s1), .res(q1y), .diff(unused_d2y));
	cbz_lerp u_l1_q2y (.clk, .en(en_l1), .a(regs_q[cbz_pkg::REG_CTRL_B_Y]),
		.b(regs_q[cbz_pkg::REG_END_Y]), .t(t_s1), .res(q2y), .diff(unused_d3y));

	// Level two.
	cbz_lerp u_l2_r0x (.clk, .en(en_l2), .a(q0x), .b(q1x), .t(t_s4), .res(r0x),
		.diff(unused_d4x));
	cbz_lerp u_l2_r1x (.clk, .en(en_l2), .a(q1x), .b(q2x), .t(t_s4), .res(r1x),
		.diff(unused_d5x));
	cbz_lerp u_l2_r0y (.clk, .en(en_l2), .a(q0y), .b(q1y), .t(t_s4), .res(r0y),
		.diff(unused_d4y));
	cbz_lerp u_l2_r1y (.clk, .en(en_l2), .a(q1y), .b(q2y), .t(t_s4), .res(r1y),
		.diff(unused_d5y));

	// Level three: the point, and r1 - r0 for the tangent.
	cbz_lerp u_l3_px (.clk, .en(en_l3), .a(r0x), .b(r1x), .t(t_s7), .res(px), .diff(dx));
	cbz_lerp u_l3_py (.clk, .en(en_l3), .a(r0y), .b(r1y), .t(t_s7), .res(py), .diff(dy));

	// The tangent is 3 * (r1 - r0), formed as d + 2d next to the level-three multiply.
	always_ff @(posedge clk) begin
		if (load[8]) begin
			tri_x_s8 <= cbz_pkg::TRI_W'(dx) + (cbz_pkg::TRI_W'(dx) <<< 1);
			tri_y_s8 <= cbz_pkg::TRI_W'(dy) + (cbz_pkg::TRI_W'(dy) <<< 1);
		end
	end

	// Clamp to 32 bits: the value fits when its top bits all equal the sign.
	always_comb begin
		sat_x_c = (tri_x_s8[cbz_pkg::TRI_W-1:cbz_pkg::COORD_W-1] != '0) &&
			(tri_x_s8[cbz_pkg::TRI_W-1:cbz_pkg::COORD_W-1] != '1);
		sat_y_c = (tri_y_s8[cbz_pkg::TRI_W-1:cbz_pkg::COORD_W-1] != '0) &&
			(tri_y_s8[cbz_pkg::TRI_W-1:cbz_pkg::COORD_W-1] != '1);
		if (!sat_x_c) begin
			tan_x_c = tri_x_s8[cbz_pkg::COORD_W-1:0];
		end else if (tri_x_s8[cbz_pkg::TRI_W-1]) begin
			tan_x_c = cbz_pkg::COORD_MIN;
		end else begin
			tan_x_c = cbz_pkg::COORD_MAX;
		end
		if (!sat_y_c) begin
			tan_y_c = tri_y_s8[cbz_pkg::COORD_W-1:0];
		end else if (tri_y_s8[cbz_pkg::TRI_W-1]) begin
			tan_y_c = cbz_pkg::COORD_MIN;
		end else begin
			tan_y_c = cbz_pkg::COORD_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (load[9]) begin
			tan_x_s9 <= tan_x_c;
			tan_y_s9 <= tan_y_c;
			sat_s9   <= sat_x_c || sat_y_c;
		end
	end

	assign m_axis_tvalid = valid_q[cbz_pkg::NUM_STAGES];
	assign m_axis_tdata  = {tan_y_s9, tan_x_s9, py, px};
	assign m_axis_tuser  = sat_s9;

	`include "cubic_bezier_point_and_tangent_core_assert.svh"

	`CBZ_ASSERT_IMPL(a_full_when_blocked, clk, arst_n, !s_axis_tready, &valid_q, "input blocked with a free pipeline stage")
	`CBZ_ASSERT_IMPL(a_t_clamped, clk, arst_n, valid_q[1], t_s1 <= cbz_pkg::T_ONE, "parameter above one entered the pipeline")
	`CBZ_ASSERT_IMPL(a_sat_extreme, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], tan_x_s9 == cbz_pkg::COORD_MAX || tan_x_s9 == cbz_pkg::COORD_MIN || tan_y_s9 == cbz_pkg::COORD_MAX || tan_y_s9 == cbz_pkg::COORD_MIN, "saturation flag without a clamped tangent")
	`CBZ_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_axis_tvalid && s_axis_tready, valid_q[1], "accepted word did not enter the first stage")

endmodule

[hw/rtl/cbz_lerp.sv]
// One pipelined fixed-point interpolation a + round((b - a) * t), three register stages.
// Depends on cbz_pkg for widths and the stage enable struct.
module cbz_lerp (
	input  logic                                  clk,
	input  cbz_pkg::lerp_en_t                     en,
	input  logic signed [cbz_pkg::COORD_W-1:0]    a,
	input  logic signed [cbz_pkg::COORD_W-1:0]    b,
	input  logic        [cbz_pkg::T_W-1:0]        t,    // aligned with the difference stage
	output logic signed [cbz_pkg::COORD_W-1:0]    res,
	output logic signed [cbz_pkg::DIFF_W-1:0]     diff
);

	localparam logic signed [cbz_pkg::PROD_W-1:0] ROUND_HALF =
		cbz_pkg::PROD_W'(1) << (cbz_pkg::T_FRAC_BITS - 1);

	logic signed [cbz_pkg::DIFF_W-1:0]              diff_s1;
	logic signed [cbz_pkg::COORD_W-1:0]             a_s1;
	logic signed [cbz_pkg::PROD_W-1:0]              prod_s2;
	logic signed [cbz_pkg::COORD_W-1:0]             a_s2;
	logic signed [cbz_pkg::COORD_W-1:0]             res_s3;
	logic signed [cbz_pkg::T_W:0]                   t_sgn;
	logic signed [cbz_pkg::PROD_W-1:0]              rounded;
	logic signed [cbz_pkg::PROD_W-cbz_pkg::T_FRAC_BITS-1:0] step;
	logic signed [cbz_pkg::PROD_W-cbz_pkg::T_FRAC_BITS-1:0] sum;

	assign t_sgn   = $signed({1'b0, t});
	assign rounded = prod_s2 + ROUND_HALF;
	// Arithmetic shift gives floor division, so ties round toward +infinity.
	assign step    = rounded[cbz_pkg::PROD_W-1:cbz_pkg::T_FRAC_BITS];
	assign sum     = ($bits(sum))'(a_s2) + step;

	always_ff @(posedge clk) begin
		if (en.d) begin
			diff_s1 <= cbz_pkg::DIFF_W'(b) - cbz_pkg::DIFF_W'(a);
			a_s1    <= a;
		end
		if (en.m) begin
			prod_s2 <= diff_s1 * t_sgn;
			a_s2    <= a_s1;
		end
		if (en.a) begin
			// The result always lies between a and b, so the low word is exact.
			res_s3 <= sum[cbz_pkg::COORD_W-1:0];
		end
	end

	assign res  = res_s3;
	assign diff = diff_s1;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the cubic Bezier point and tangent core.
// Depends on cbz_pkg and the core RTL; a directed table is followed by randomized phases,
// and every output word is checked against its typed row or a fixed-point de Casteljau predictor.
`timescale 1ns / 100ps

module testbench;

	localparam int NUM_REGS        = 8;
	localparam int PARAM_W         = cbz_pkg::T_W;
	localparam int RANDOM_PHASES   = 8;
	localparam int WORDS_PER_PHASE = 165;

	localparam logic signed [cbz_pkg::COORD_W-1:0] CMAX = cbz_pkg::COORD_MAX;
	localparam logic signed [cbz_pkg::COORD_W-1:0] CMIN = cbz_pkg::COORD_MIN;
	localparam logic [PARAM_W-1:0]                 T_ALL_ONES = '1;

	// One output word split into its fields, in the order they sit in tdata.
	typedef struct packed {
		logic signed [cbz_pkg::COORD_W-1:0] point_x;
		logic signed [cbz_pkg::COORD_W-1:0] point_y;
		logic signed [cbz_pkg::COORD_W-1:0] tangent_x;
		logic signed [cbz_pkg::COORD_W-1:0] tangent_y;
		logic                               saturated;
	} bezier_out_t;

	typedef logic signed [cbz_pkg::COORD_W-1:0] point_regs_t [NUM_REGS];

	// Named control point sets that the directed table can load before a row.
	typedef enum int {
		PTS_KEEP,
		PTS_ZIGZAG,
		PTS_ALL_MAX,
		PTS_ALL_MIN
	} point_set_t;

	typedef enum int {
		SINK_STEADY,
		SINK_COIN,
		SINK_THROTTLE,
		SINK_CHOKE
	} sink_mode_t;

	typedef struct {
		point_set_t          points;  // set to program first, or keep what is loaded
		logic [PARAM_W-1:0]  t;
		bit                  typed;   // expected word is written out in the row
		bezier_out_t         want;
	} directed_row_t;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            cfg_we        = 1'b0;
	logic [2:0]                      cfg_index     = '0;
	logic [cbz_pkg::COORD_W-1:0]     cfg_data      = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [cbz_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [cbz_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]                      m_axis_tuser;

	// Copy of the control point registers as the core should hold them.
	point_regs_t ctrl_pts = '{default: '0};

	// Words the core still owes us, oldest first.
	bezier_out_t expected_words [$];

	int mismatches = 0;
	int burst_left = 0;
	int sink_tick  = 0;

	// The directed rows. The first three run on the all-zero curve left by reset.
	// The zigzag set puts every control point at a range extreme with alternating
	// signs, so the end slopes overflow and clamp; the flat sets give a constant
	// point and a zero tangent. Rows that are not typed go through the predictor.
	directed_row_t directed_rows [19] = '{
		'{PTS_KEEP,    17'h00000, 1'b1, '0},
		'{PTS_KEEP,    cbz_pkg::T_ONE, 1'b1, '0},
		'{PTS_KEEP,    T_ALL_ONES, 1'b1, '0},
		'{PTS_ZIGZAG,  17'h00000, 1'b1, '{CMIN, CMAX, CMAX, CMIN, 1'b1}},
		'{PTS_KEEP,    cbz_pkg::T_ONE, 1'b1, '{CMAX, CMIN, CMAX, CMIN, 1'b1}},
		'{PTS_KEEP,    17'h10001, 1'b1, '{CMAX, CMIN, CMAX, CMIN, 1'b1}},
		'{PTS_KEEP,    T_ALL_ONES, 1'b1, '{CMAX, CMIN, CMAX, CMIN, 1'b1}},
		'{PTS_KEEP,    17'h18000, 1'b1, '{CMAX, CMIN, CMAX, CMIN, 1'b1}},
		'{PTS_KEEP,    17'h00001, 1'b0, '0},
		'{PTS_KEEP,    17'h08000, 1'b0, '0},
		'{PTS_KEEP,    17'h0FFFF, 1'b0, '0},
		'{PTS_KEEP,    17'h05555, 1'b0, '0},
		'{PTS_KEEP,    17'h0AAAA, 1'b0, '0},
		'{PTS_KEEP,    17'h00100, 1'b0, '0},
		'{PTS_ALL_MAX, 17'h0C350, 1'b1, '{CMAX, CMAX, 32'sd0, 32'sd0, 1'b0}},
		'{PTS_KEEP,    T_ALL_ONES, 1'b1, '{CMAX, CMAX, 32'sd0, 32'sd0, 1'b0}},
		'{PTS_ALL_MIN, 17'h00000, 1'b1, '{CMIN, CMIN, 32'sd0, 32'sd0, 1'b0}},
		'{PTS_KEEP,    17'h08000, 1'b1, '{CMIN, CMIN, 32'sd0, 32'sd0, 1'b0}},
		'{PTS_KEEP,    cbz_pkg::T_ONE, 1'b1, '{CMIN, CMIN, 32'sd0, 32'sd0, 1'b0}}
	};

	cubic_bezier_point_and_tangent_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// One interpolation step: a + (b - a) * t / ONE, rounded to nearest with ties
	// going up. The arithmetic shift of a signed value is a floor, which is exactly
	// that rounding once half a unit has been added.
	function automatic longint interp(longint a, longint b, longint t);
		return a + (((b - a) * t + (longint'(1) <<< (cbz_pkg::T_FRAC_BITS - 1)))
			>>> cbz_pkg::T_FRAC_BITS);
	endfunction

	// Three levels of subdivision on one axis. The tangent is three times the
	// span of the second level, clamped to 32 bits; a clamp sets the flag.
	function automatic void curve_axis(input longint p0, input longint p1, input longint p2,
			input longint p3, input longint t, output longint pt, output longint slope,
			inout logic clamped);
		longint q0, q1, q2, r0, r1;
		q0 = interp(p0, p1, t);
		q1 = interp(p1, p2, t);
		q2 = interp(p2, p3, t);
		r0 = interp(q0, q1, t);
		r1 = interp(q1, q2, t);
		pt = interp(r0, r1, t);
		slope = 3 * (r1 - r0);
		if (slope > longint'(CMAX)) begin
			slope = longint'(CMAX);
			clamped = 1'b1;
		end else if (slope < longint'(CMIN)) begin
			slope = longint'(CMIN);
			clamped = 1'b1;
		end
	endfunction

	// Point and tangent the core should return for parameter t on the loaded curve.
	// A t past one is treated as one and does not count as a clamp.
	function automatic bezier_out_t bezier_at(logic [PARAM_W-1:0] t);
		bezier_out_t res;
		longint tt, px, py, tx, ty;
		logic clamped;
		tt = (t > cbz_pkg::T_ONE) ? longint'(cbz_pkg::T_ONE) : longint'(t);
		clamped = 1'b0;
		curve_axis(ctrl_pts[cbz_pkg::REG_START_X], ctrl_pts[cbz_pkg::REG_CTRL_A_X],
			ctrl_pts[cbz_pkg::REG_CTRL_B_X], ctrl_pts[cbz_pkg::REG_END_X], tt, px, tx,
			clamped);
		curve_axis(ctrl_pts[cbz_pkg::REG_START_Y], ctrl_pts[cbz_pkg::REG_CTRL_A_Y],
			ctrl_pts[cbz_pkg::REG_CTRL_B_Y], ctrl_pts[cbz_pkg::REG_END_Y], tt, py, ty,
			clamped);
		res.point_x   = px[cbz_pkg::COORD_W-1:0];
		res.point_y   = py[cbz_pkg::COORD_W-1:0];
		res.tangent_x = tx[cbz_pkg::COORD_W-1:0];
		res.tangent_y = ty[cbz_pkg::COORD_W-1:0];
		res.saturated = clamped;
		return res;
	endfunction

	function automatic point_regs_t point_set(point_set_t s);
		point_regs_t v;
		v = '{default: '0};
		case (s)
			PTS_ZIGZAG: begin
				v[cbz_pkg::REG_START_X]  = CMIN;
				v[cbz_pkg::REG_START_Y]  = CMAX;
				v[cbz_pkg::REG_CTRL_A_X] = CMAX;
				v[cbz_pkg::REG_CTRL_A_Y] = CMIN;
				v[cbz_pkg::REG_CTRL_B_X] = CMIN;
				v[cbz_pkg::REG_CTRL_B_Y] = CMAX;
				v[cbz_pkg::REG_END_X]    = CMAX;
				v[cbz_pkg::REG_END_Y]    = CMIN;
			end
			PTS_ALL_MAX: v = '{default: CMAX};
			PTS_ALL_MIN: v = '{default: CMIN};
			default: ;
		endcase
		return v;
	endfunction

	// Narrow phases keep every coordinate within +-0x100000 so the tangent never clamps;
	// wide phases mix full-range values, narrow values, zero and both extremes.
	function automatic logic signed [cbz_pkg::COORD_W-1:0] random_coord(bit wide);
		if (!wide)
			return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		case ($urandom_range(0, 9))
			0:       return CMAX;
			1:       return CMIN;
			2:       return '0;
			3, 4:    return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			default: return $urandom;
		endcase
	endfunction

	// Mostly t inside [0, 1], with the end points, tiny values and values past one.
	function automatic logic [PARAM_W-1:0] random_param();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return cbz_pkg::T_ONE;
			2:       return PARAM_W'($urandom_range(int'(cbz_pkg::T_ONE) + 1,
					int'(T_ALL_ONES)));
			3:       return PARAM_W'($urandom_range(0, 15));
			default: return PARAM_W'($urandom_range(0, int'(cbz_pkg::T_ONE)));
		endcase
	endfunction

	// Writes all eight registers on back-to-back cycles; only call while idle.
	task automatic program_points(input point_regs_t v);
		cbz_pkg::cfg_reg_t idx;
		for (int i = 0; i < NUM_REGS; i++) begin
			idx = cbz_pkg::cfg_reg_t'(i);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= v[i];
			ctrl_pts[i] = v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Holds the input off until every owed word has come back, then lets the
	// pipeline settle. Every input word makes exactly one output word, so an
	// empty queue means an empty pipeline.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (cbz_pkg::NUM_STAGES) @(posedge clk);
	endtask

	// Offers one word and returns once the core has taken it. The sender runs in
	// bursts; a new burst may start with a gap of idle cycles or run straight on.
	// tvalid stays high between words of a burst, so it is never lowered and
	// raised in the same step.
	task automatic send_word(input logic [PARAM_W-1:0] t, input bezier_out_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(cbz_pkg::IN_TDATA_W - PARAM_W){1'b0}}, t};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_words.push_back(want);
	endtask

	// Output side: the ready pattern switches between modes every so often,
	// including long stretches where the core is never stalled.
	initial begin : sink_pattern
		sink_mode_t mode;
		int span;
		forever begin
			mode = sink_mode_t'($urandom_range(0, 3));
			span = $urandom_range(32, 256);
			repeat (span) begin
				@(posedge clk);
				sink_tick++;
				case (mode)
					SINK_STEADY:   m_axis_tready <= 1'b1;
					SINK_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
					SINK_THROTTLE: m_axis_tready <= (sink_tick % 4) == 0;
					SINK_CHOKE:    m_axis_tready <= (sink_tick % 16) >= 12;
					default:       m_axis_tready <= 1'b1;
				endcase
			end
		end
	end

	// Scoreboard: every word taken at the output is matched against the oldest
	// expectation, one field at a time. Values sampled here are the ones the core
	// saw at this edge, since all stimulus changes land in the update region.
	always @(posedge clk) begin : word_check
		bezier_out_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.point_x   = m_axis_tdata[0*cbz_pkg::COORD_W +: cbz_pkg::COORD_W];
			got.point_y   = m_axis_tdata[1*cbz_pkg::COORD_W +: cbz_pkg::COORD_W];
			got.tangent_x = m_axis_tdata[2*cbz_pkg::COORD_W +: cbz_pkg::COORD_W];
			got.tangent_y = m_axis_tdata[3*cbz_pkg::COORD_W +: cbz_pkg::COORD_W];
			got.saturated = m_axis_tuser[0];
			if (expected_words.size() == 0) begin
				$error("output word with nothing expected: point_x %0d", got.point_x);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (got.point_x !== want.point_x) begin
					$error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
					mismatches++;
				end
				if (got.point_y !== want.point_y) begin
					$error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
					mismatches++;
				end
				if (got.tangent_x !== want.tangent_x) begin
					$error("tangent_x: expected %0d, got %0d", want.tangent_x, got.tangent_x);
					mismatches++;
				end
				if (got.tangent_y !== want.tangent_y) begin
					$error("tangent_y: expected %0d, got %0d", want.tangent_y, got.tangent_y);
					mismatches++;
				end
				if (got.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
					mismatches++;
				end
			end
		end
	end

	// Main sequence: reset, the directed table, then random phases, each phase
	// starting from an idle core with a fresh set of control points.
	initial begin : stimulus
		point_regs_t pts;
		logic [PARAM_W-1:0] t;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].points != PTS_KEEP) begin
				wait_idle();
				program_points(point_set(directed_rows[i].points));
			end
			send_word(directed_rows[i].t, directed_rows[i].typed ?
				directed_rows[i].want : bezier_at(directed_rows[i].t));
		end

		// Every register gets random values here; even phases stay narrow so
		// unclamped tangents and fine rounding are well covered.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			foreach (pts[i])
				pts[i] = random_coord(phase % 2 == 1);
			program_points(pts);
			repeat (WORDS_PER_PHASE) begin
				t = random_param();
				send_word(t, bezier_at(t));
			end
		end

		// Drain, then give a stray extra word time to show up.
		wait_idle();
		repeat (4 * cbz_pkg::NUM_STAGES) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("** cubic_bezier_point_and_tangent_core: PASSED **");
		end else begin
			$display("** cubic_bezier_point_and_tangent_core: FAILED **");
		end
		$finish;
	end

	// A correct run needs well under a quarter of this.
	initial begin : watchdog
		#2ms;
		$display("** cubic_bezier_point_and_tangent_core: FAILED **");
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/cbz_pkg.sv
hw/rtl/cbz_lerp.sv
hw/rtl/cubic_bezier_point_and_tangent_core.sv
tb/testbench.sv
